// ===== hw/rtl/tgt_pkg.sv =====
// Package for the twiddle gain tuner: phase codes, register indexes, fixed-point helpers.
`default_nettype none

package tgt_pkg;

    localparam int FRAC_BITS = 16;

    // tolerance reset value: 0.2 in the fixed-point format
    localparam logic [31:0] TOL_RESET = 32'((64'd1 << FRAC_BITS) / 5);

    // reciprocal of 10 scaled by 2^35; exact floor for every 32-bit operand
    localparam logic [31:0] DIV10_RECIP = 32'hCCCC_CCCD;
    localparam int          DIV10_SHIFT = 35;

    localparam logic signed [33:0] S34_MAX = 34'sd2147483647;
    localparam logic signed [33:0] S34_MIN = -34'sd2147483648;

    typedef logic [31:0] word_t;
    typedef logic [1:0]  gain_idx_t;

    typedef enum logic [1:0] {
        PH_INC   = 2'd0,
        PH_CHECK = 2'd1,
        PH_DEC   = 2'd2,
        PH_DONE  = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        REG_GAIN_P = 2'd0,
        REG_GAIN_I = 2'd1,
        REG_GAIN_D = 2'd2,
        REG_TOL    = 2'd3
    } reg_idx_t;

    localparam gain_idx_t IDX_P    = 2'd0;
    localparam gain_idx_t IDX_LAST = 2'd2;

    function automatic logic signed [33:0] sx34(input word_t v);
        return signed'({{2{v[31]}}, v});
    endfunction

    function automatic word_t sat34(input logic signed [33:0] v);
        word_t r;
        if (v > S34_MAX)
            r = 32'h7FFF_FFFF;
        else if (v < S34_MIN)
            r = 32'h8000_0000;
        else
            r = v[31:0];
        return r;
    endfunction

    // floor(m / 10) for unsigned m
    function automatic word_t div10(input word_t m);
        logic [63:0] prod;
        prod = 64'(m) * 64'(DIV10_RECIP);
        return 32'(prod[63:DIV10_SHIFT]);
    endfunction

    function automatic word_t magnitude(input word_t x);
        return x[31] ? (~x + 32'd1) : x;
    endfunction

    // x / 10, truncated toward zero
    function automatic word_t sdiv10(input word_t x);
        word_t q;
        q = div10(magnitude(x));
        return x[31] ? (~q + 32'd1) : q;
    endfunction

    // x * 11 / 10, truncated toward zero, saturated
    function automatic word_t step_grow(input word_t x);
        word_t       m;
        logic [32:0] v;
        word_t       r;
        m = magnitude(x);
        v = {1'b0, m} + {1'b0, div10(m)};
        if (!x[31])
            r = (v > 33'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : v[31:0];
        else
            r = (v > 33'h0_8000_0000) ? 32'h8000_0000 : (~v[31:0] + 32'd1);
        return r;
    endfunction

    // x * 9 / 10, truncated toward zero: |x| - ceil(|x| / 10)
    function automatic word_t step_shrink(input word_t x);
        word_t m;
        word_t v;
        m = magnitude(x);
        v = m - div10(m + 32'd9);
        return x[31] ? (~v + 32'd1) : v;
    endfunction

    function automatic logic below_tol(input word_t s0, input word_t s1, input word_t s2,
                                       input word_t tol);
        logic signed [33:0] sum;
        sum = sx34(s0) + sx34(s1) + sx34(s2);
        return sum < signed'({2'b00, tol});
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/twiddle_gain_tuner_core.sv =====
// Twiddle coordinate-descent tuner for three PID gains, one run error per request.
// Latency: a result is valid the cycle after its request is accepted.
// Throughput: one request per cycle while m_tready takes the result; the result register frees as it is taken.
// The critical path is the tolerance/step update feeding the 32x32 reciprocal
// multipliers that prepare the grown and shrunk step for the next request.
// Reset (rst_n low, async): gains, steps, best error and phase clear, tuning restarts.
`default_nettype none

module twiddle_gain_tuner_core (
    input  wire logic         clk,
    input  wire logic         rst_n,
    // input request: [31:0] run_error
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [31:0]  s_tdata,
    // result: [31:0] gain_p, [63:32] gain_i, [95:64] gain_d, [127:96] best_error,
    //         [129:128] tuning_phase, [131:130] active_gain, [135:132] zero
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [135:0]      m_tdata,
    // configuration writes
    input  wire logic         cfg_we,
    input  wire tgt_pkg::reg_idx_t cfg_addr,
    input  wire logic [31:0]  cfg_data
);
    import tgt_pkg::*;

    // configuration; the initial step (gain / 10) is worked out at write time
    word_t init_gain_reg [3];
    word_t init_step_reg [3];
    word_t tol_reg;
    word_t cfg_step;

    // tuner state
    word_t     gains_reg [3];
    word_t     steps_reg [3];
    word_t     best_reg;
    phase_t    phase_reg;
    gain_idx_t gain_index_reg;
    logic      started_reg;
    // step of the gain tuned next, already grown and shrunk
    word_t     grow_reg;
    word_t     shrink_reg;

    word_t     gains_next [3];
    word_t     steps_next [3];
    word_t     best_next;
    phase_t    phase_next;
    gain_idx_t gain_index_next;
    word_t     sel_step;

    // result register
    logic         out_valid_reg;
    logic [135:0] out_data_reg;

    logic  accept;
    word_t run_error;

    assign run_error = s_tdata;
    assign accept    = s_tvalid && s_tready;
    assign cfg_step  = sdiv10(cfg_data);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
            begin
                init_gain_reg[i] <= '0;
                init_step_reg[i] <= '0;
            end
            tol_reg <= TOL_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_GAIN_P:
                begin
                    init_gain_reg[0] <= cfg_data;
                    init_step_reg[0] <= cfg_step;
                end
                REG_GAIN_I:
                begin
                    init_gain_reg[1] <= cfg_data;
                    init_step_reg[1] <= cfg_step;
                end
                REG_GAIN_D:
                begin
                    init_gain_reg[2] <= cfg_data;
                    init_step_reg[2] <= cfg_step;
                end
                REG_TOL:    tol_reg <= cfg_data;
                default:    ;
            endcase
        end
    end

    // next state for one request
    always_comb
    begin
        gain_idx_t k;
        logic      adv;

        best_next = started_reg ? best_reg : run_error;
        for (int i = 0; i < 3; i++)
        begin
            gains_next[i] = started_reg ? gains_reg[i] : init_gain_reg[i];
            steps_next[i] = started_reg ? steps_reg[i] : init_step_reg[i];
        end
        k          = (gain_index_reg > IDX_LAST) ? IDX_P : gain_index_reg;
        gain_index_next = k;
        phase_next = phase_reg;
        adv        = 1'b0;

        if (below_tol(steps_next[0], steps_next[1], steps_next[2], tol_reg))
            phase_next = PH_DONE;

        case (phase_next)
            PH_INC:
            begin
                gains_next[k] = sat34(sx34(gains_next[k]) + sx34(steps_next[k]));
                phase_next    = PH_CHECK;
            end
            PH_CHECK:
            begin
                if (run_error < best_next)
                begin
                    best_next     = run_error;
                    steps_next[k] = grow_reg;
                    adv           = 1'b1;
                end
                else
                begin
                    gains_next[k] = sat34(sx34(gains_next[k])
                                          - (sx34(steps_next[k]) <<< 1));
                    phase_next    = PH_DEC;
                end
            end
            PH_DEC:
            begin
                if (run_error < best_next)
                begin
                    best_next     = run_error;
                    steps_next[k] = grow_reg;
                end
                else
                begin
                    gains_next[k] = sat34(sx34(gains_next[k]) + sx34(steps_next[k]));
                    steps_next[k] = shrink_reg;
                end
                adv = 1'b1;
            end
            default: ;
        endcase

        // move to the next gain and apply its increment right away
        if (adv)
        begin
            gain_index_next = (k >= IDX_LAST) ? IDX_P : k + 2'd1;
            if (below_tol(steps_next[0], steps_next[1], steps_next[2], tol_reg))
                phase_next = PH_DONE;
            else
            begin
                gains_next[gain_index_next] = sat34(sx34(gains_next[gain_index_next])
                                                    + sx34(steps_next[gain_index_next]));
                phase_next = PH_CHECK;
            end
        end
    end

    assign sel_step = steps_next[gain_index_next];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
            begin
                gains_reg[i] <= '0;
                steps_reg[i] <= '0;
            end
            best_reg       <= '0;
            phase_reg      <= PH_INC;
            gain_index_reg <= IDX_P;
            started_reg    <= 1'b0;
            grow_reg       <= '0;
            shrink_reg     <= '0;
        end
        else if (accept)
        begin
            gains_reg      <= gains_next;
            steps_reg      <= steps_next;
            best_reg       <= best_next;
            phase_reg      <= phase_next;
            gain_index_reg <= gain_index_next;
            started_reg    <= 1'b1;
            grow_reg       <= step_grow(sel_step);
            shrink_reg     <= step_shrink(sel_step);
        end
    end

    // result register; a new request is taken whenever the slot is free or draining
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (accept)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            out_data_reg <= {4'd0, gain_index_next, phase_next, best_next,
                             gains_next[2], gains_next[1], gains_next[0]};
    end

    always_comb
    begin
        s_tready = !out_valid_reg || m_tready;
        m_tvalid = out_valid_reg;
        m_tdata  = out_data_reg;
    end

`ifndef SYNTH
    a_done_holds: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_DONE |=> phase_reg == PH_DONE)
        else $error("done phase left without reset");

    a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        gain_index_reg != 2'd3)
        else $error("gain index out of range");

    a_best_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && started_reg) |=> best_reg <= $past(best_reg))
        else $error("best error increased");

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> m_tvalid && m_tdata[127:96] == best_reg)
        else $error("result missing after accepted request");
`endif

endmodule

`default_nettype wire
